// ----- hw/rtl/dpdt_pkg.sv -----
`default_nettype none
package dpdt_pkg;

	localparam int unsigned ERR_W     = 16;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned DIFF_W    = 32;
	localparam int unsigned INTEG_W   = 32;
	localparam int unsigned ITERM_W   = 33;
	localparam int unsigned DTERM_W   = 48;
	localparam int unsigned SUM_W     = 50;
	localparam int unsigned MIX_W     = 51;
	localparam int unsigned THRUST_W  = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 16;

	localparam int unsigned I_SHIFT        = 15;
	localparam int unsigned FRAC_OUT_SHIFT = 6;
	localparam logic [15:0] SILENT_MAX     = 16'hFFFF;
	localparam logic signed [MIX_W-1:0] THRUST_MAX = 51'sd16384;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_KP_X      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_X      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KD_X      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_Y      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_Y      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KD_Y      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DT_SHIFT  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 4'd7;

	localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd2048;
	localparam logic [3:0]  DT_SHIFT_RESET  = 4'd4;
	localparam logic [15:0] HEARTBEAT_RESET = 16'd160;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} dpdt_gain_t;

	// Per-axis operands handed from the state update to the multipliers.
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [DIFF_W-1:0]  diff;
		logic signed [INTEG_W-1:0] integ;
	} dpdt_axis_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dpdt_if.sv -----
`default_nettype none
interface dpdt_in_if;
	logic valid;
	logic ready;
	logic x_valid;
	logic signed [15:0] x_error;
	logic y_valid;
	logic signed [15:0] y_error;

	modport source(output valid, output x_valid, output x_error, output y_valid,
		output y_error, input ready);
	modport sink(input valid, input x_valid, input x_error, input y_valid,
		input y_error, output ready);
endinterface

interface dpdt_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] thrust_left;
	logic signed [15:0] thrust_right;
	logic timed_out;

	modport source(output valid, output thrust_left, output thrust_right,
		output timed_out, input ready);
	modport sink(input valid, input thrust_left, input thrust_right,
		input timed_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dpdt_front.sv -----
`default_nettype none
module dpdt_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic acc,
	input  wire logic x_valid,
	input  wire logic signed [dpdt_pkg::ERR_W-1:0] x_error,
	input  wire logic y_valid,
	input  wire logic signed [dpdt_pkg::ERR_W-1:0] y_error,
	input  wire logic [3:0] dt_shift,
	input  wire logic [15:0] heartbeat_ticks,
	output dpdt_pkg::dpdt_axis_t ax_s1,
	output dpdt_pkg::dpdt_axis_t ay_s1,
	output logic tout_s1
);

	logic signed [dpdt_pkg::ERR_W-1:0]   cur_x_q, prev_x_q, cur_y_q, prev_y_q;
	logic signed [dpdt_pkg::INTEG_W-1:0] integ_x_q, integ_y_q;
	logic [15:0] silent_q;

	logic signed [dpdt_pkg::ERR_W-1:0]   cx, px, cy, py;
	logic signed [dpdt_pkg::INTEG_W-1:0] bx, by, ix, iy;
	logic signed [dpdt_pkg::DIFF_W-1:0]  dx, dy;
	logic [15:0] silent_n;
	logic [3:0]  ishift;

	function automatic logic signed [dpdt_pkg::DIFF_W-1:0] diff_shift(
		input logic signed [dpdt_pkg::ERR_W-1:0] e,
		input logic signed [dpdt_pkg::ERR_W-1:0] p,
		input logic [3:0] sh);
		logic signed [dpdt_pkg::ERR_W:0] d;
		logic signed [dpdt_pkg::DIFF_W-1:0] w;
		d = (dpdt_pkg::ERR_W+1)'(e) - (dpdt_pkg::ERR_W+1)'(p);
		w = dpdt_pkg::DIFF_W'(d);
		return w <<< sh;
	endfunction

	function automatic logic signed [dpdt_pkg::INTEG_W-1:0] integ_step(
		input logic signed [dpdt_pkg::INTEG_W-1:0] base,
		input logic signed [dpdt_pkg::ERR_W-1:0] e,
		input logic [3:0] sh);
		logic signed [dpdt_pkg::INTEG_W-1:0] inc;
		logic signed [dpdt_pkg::INTEG_W:0] s;
		logic signed [dpdt_pkg::INTEG_W-1:0] r;
		inc = dpdt_pkg::INTEG_W'(e) <<< sh;
		s = (dpdt_pkg::INTEG_W+1)'(base) + (dpdt_pkg::INTEG_W+1)'(inc);
		// Saturate when the carry out disagrees with the sign.
		if (s[dpdt_pkg::INTEG_W] != s[dpdt_pkg::INTEG_W-1]) begin
			r = {s[dpdt_pkg::INTEG_W], {(dpdt_pkg::INTEG_W-1){~s[dpdt_pkg::INTEG_W]}}};
		end else begin
			r = s[dpdt_pkg::INTEG_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		ishift = 4'd15 - dt_shift;

		cx = x_valid ? x_error : cur_x_q;
		px = prev_x_q;
		bx = integ_x_q;
		if (x_valid) begin
			px = cur_x_q;
			if (x_error == '0) begin
				px = '0;
				bx = '0;
			end
		end

		cy = y_valid ? y_error : cur_y_q;
		py = prev_y_q;
		by = integ_y_q;
		if (y_valid) begin
			py = cur_y_q;
			if (y_error == '0) begin
				py = '0;
				by = '0;
			end
		end

		dx = diff_shift(cx, px, dt_shift);
		dy = diff_shift(cy, py, dt_shift);
		ix = integ_step(bx, cx, ishift);
		iy = integ_step(by, cy, ishift);

		if (x_valid) begin
			silent_n = '0;
		end else if (silent_q != dpdt_pkg::SILENT_MAX) begin
			silent_n = silent_q + 16'd1;
		end else begin
			silent_n = silent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			prev_x_q  <= '0;
			integ_x_q <= '0;
			cur_y_q   <= '0;
			prev_y_q  <= '0;
			integ_y_q <= '0;
			silent_q  <= dpdt_pkg::SILENT_MAX;
		end else if (acc) begin
			cur_x_q   <= cx;
			// The x axis hands its current error to prev on every tick.
			prev_x_q  <= cx;
			integ_x_q <= ix;
			cur_y_q   <= cy;
			prev_y_q  <= py;
			integ_y_q <= iy;
			silent_q  <= silent_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ax_s1   <= '{err: cx, diff: dx, integ: ix};
			ay_s1   <= '{err: cy, diff: dy, integ: iy};
			tout_s1 <= (silent_n >= heartbeat_ticks);
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dpdt_axis.sv -----
`default_nettype none
module dpdt_axis (
	input  wire logic clk,
	input  wire logic ld_s2,
	input  wire logic ld_s3,
	input  wire dpdt_pkg::dpdt_gain_t gain,
	input  wire dpdt_pkg::dpdt_axis_t op_s1,
	output logic signed [dpdt_pkg::SUM_W-1:0] u_s3
);

	logic signed [2*dpdt_pkg::ERR_W-1:0]  p_s2;
	logic signed [dpdt_pkg::ITERM_W-1:0]  i_s2;
	logic signed [dpdt_pkg::DTERM_W-1:0]  d_s2;
	logic signed [dpdt_pkg::GAIN_W+dpdt_pkg::INTEG_W-1:0] ki_prod;
	logic signed [dpdt_pkg::GAIN_W+dpdt_pkg::INTEG_W-1:0] ki_shr;

	always_comb begin
		ki_prod = gain.ki * op_s1.integ;
		ki_shr  = ki_prod >>> dpdt_pkg::I_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			p_s2 <= gain.kp * op_s1.err;
			i_s2 <= ki_shr[dpdt_pkg::ITERM_W-1:0];
			d_s2 <= gain.kd * op_s1.diff;
		end
		if (ld_s3) begin
			u_s3 <= dpdt_pkg::SUM_W'(p_s2) + dpdt_pkg::SUM_W'(i_s2)
				+ dpdt_pkg::SUM_W'(d_s2);
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dpdt_mix.sv -----
`default_nettype none
module dpdt_mix (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_s3,
	input  wire logic tout_s3,
	input  wire logic signed [dpdt_pkg::SUM_W-1:0] ux_s3,
	input  wire logic signed [dpdt_pkg::SUM_W-1:0] uy_s3,
	output logic rdy_out,
	dpdt_out_if.source out_ch
);

	logic valid_q;
	logic signed [dpdt_pkg::THRUST_W-1:0] left_q, right_q;
	logic tout_q;
	logic signed [dpdt_pkg::MIX_W-1:0] l_sum, r_sum;
	logic signed [dpdt_pkg::THRUST_W-1:0] l_cl, r_cl;

	function automatic logic signed [dpdt_pkg::THRUST_W-1:0] to_thrust(
		input logic signed [dpdt_pkg::MIX_W-1:0] v);
		logic signed [dpdt_pkg::MIX_W-1:0] t;
		logic signed [dpdt_pkg::MIX_W-1:0] c;
		t = v >>> dpdt_pkg::FRAC_OUT_SHIFT;
		if (t > dpdt_pkg::THRUST_MAX) begin
			c = dpdt_pkg::THRUST_MAX;
		end else if (t < -dpdt_pkg::THRUST_MAX) begin
			c = -dpdt_pkg::THRUST_MAX;
		end else begin
			c = t;
		end
		return c[dpdt_pkg::THRUST_W-1:0];
	endfunction

	always_comb begin
		r_sum = dpdt_pkg::MIX_W'(uy_s3) + dpdt_pkg::MIX_W'(ux_s3);
		l_sum = dpdt_pkg::MIX_W'(uy_s3) - dpdt_pkg::MIX_W'(ux_s3);
		r_cl  = tout_s3 ? '0 : to_thrust(r_sum);
		l_cl  = tout_s3 ? '0 : to_thrust(l_sum);
		rdy_out = !valid_q || out_ch.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy_out) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s3) begin
			left_q  <= l_cl;
			right_q <= r_cl;
			tout_q  <= tout_s3;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.thrust_left  = left_q;
	assign out_ch.thrust_right = right_q;
	assign out_ch.timed_out    = tout_q;

endmodule
`default_nettype wire

// ----- hw/rtl/dual_pid_differential_thrust.sv -----
`default_nettype none
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   x_valid, x_error, y_valid, y_error
// out_ch   out  valid/ready   thrust_left, thrust_right, timed_out
// cfg      in   cfg_we        cfg_index, cfg_data
//
// One item can be taken every cycle while the output does not stall; it
// passes through the state update, multipliers, axis sums, then mixer and
// clamp into the output register.
// The controller state is updated in the accept cycle, so the next item
// sees it at once. A stage holds its item while the next stage is full and
// stalled; ready runs combinationally from the output back to the input.
// After reset the block is timed out until an x sample arrives.
module dual_pid_differential_thrust (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [dpdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dpdt_pkg::CFG_DAT_W-1:0] cfg_data,
	dpdt_in_if.sink   in_ch,
	dpdt_out_if.source out_ch
);

	dpdt_pkg::dpdt_gain_t gain_x_q, gain_y_q;
	logic [3:0]  dt_shift_q;
	logic [15:0] heartbeat_q;

	logic valid_s1, valid_s2, valid_s3;
	logic tout_s1, tout_s2, tout_s3;
	logic rdy1, rdy2, rdy3, rdy_out;
	logic acc;
	dpdt_pkg::dpdt_axis_t ax_s1, ay_s1;
	logic signed [dpdt_pkg::SUM_W-1:0] ux_s3, uy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q    <= '{kp: dpdt_pkg::KP_RESET, ki: '0, kd: '0};
			gain_y_q    <= '{kp: dpdt_pkg::KP_RESET, ki: '0, kd: '0};
			dt_shift_q  <= dpdt_pkg::DT_SHIFT_RESET;
			heartbeat_q <= dpdt_pkg::HEARTBEAT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dpdt_pkg::CFG_KP_X:      gain_x_q.kp <= cfg_data;
				dpdt_pkg::CFG_KI_X:      gain_x_q.ki <= cfg_data;
				dpdt_pkg::CFG_KD_X:      gain_x_q.kd <= cfg_data;
				dpdt_pkg::CFG_KP_Y:      gain_y_q.kp <= cfg_data;
				dpdt_pkg::CFG_KI_Y:      gain_y_q.ki <= cfg_data;
				dpdt_pkg::CFG_KD_Y:      gain_y_q.kd <= cfg_data;
				dpdt_pkg::CFG_DT_SHIFT:  dt_shift_q  <= cfg_data[3:0];
				dpdt_pkg::CFG_HEARTBEAT: heartbeat_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rdy3 = !valid_s3 || rdy_out;
		rdy2 = !valid_s2 || rdy3;
		rdy1 = !valid_s1 || rdy2;
		acc  = in_ch.valid && rdy1;
	end

	assign in_ch.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= acc;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			tout_s2 <= tout_s1;
		end
		if (rdy3 && valid_s2) begin
			tout_s3 <= tout_s2;
		end
	end

	dpdt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc             (acc),
		.x_valid         (in_ch.x_valid),
		.x_error         (in_ch.x_error),
		.y_valid         (in_ch.y_valid),
		.y_error         (in_ch.y_error),
		.dt_shift        (dt_shift_q),
		.heartbeat_ticks (heartbeat_q),
		.ax_s1           (ax_s1),
		.ay_s1           (ay_s1),
		.tout_s1         (tout_s1)
	);

	dpdt_axis u_axis_x (
		.clk   (clk),
		.ld_s2 (rdy2 && valid_s1),
		.ld_s3 (rdy3 && valid_s2),
		.gain  (gain_x_q),
		.op_s1 (ax_s1),
		.u_s3  (ux_s3)
	);

	dpdt_axis u_axis_y (
		.clk   (clk),
		.ld_s2 (rdy2 && valid_s1),
		.ld_s3 (rdy3 && valid_s2),
		.gain  (gain_y_q),
		.op_s1 (ay_s1),
		.u_s3  (uy_s3)
	);

	dpdt_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.tout_s3  (tout_s3),
		.ux_s3    (ux_s3),
		.uy_s3    (uy_s3),
		.rdy_out  (rdy_out),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire
